[design/piecewise_exponential_sampler_assert.svh]
// assertion macros shared by the sampler modules
// depends on nothing; included by files that carry concurrent assertions
`ifndef PIECEWISE_EXPONENTIAL_SAMPLER_ASSERT_SVH
`define PIECEWISE_EXPONENTIAL_SAMPLER_ASSERT_SVH
`ifndef ASSERT_OFF
`define PES_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: %m");
`define PES_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed: %m");
`else
`define PES_ASSERT(lbl, clk, rst, prop)
`define PES_ASSERT_NR(lbl, clk, prop)
`endif
`endif

[design/pes_pkg.sv]
// shared types and constants of the piecewise exponential sampler
// depends on nothing; imported by every sampler module
package pes_pkg;

   localparam int IDX_W  = 4;
   localparam int WORD_W = 32;
   localparam int CNT_W  = 5;
   localparam int W_BITS = 26;
   localparam int W_W    = 31;
   localparam int HAZ_W  = 63;

   localparam logic [31:0]      LN2_Q32 = 32'd2977044472;
   localparam logic [HAZ_W-1:0] HAZ_CAP = 63'h4000_0000_0000_0000;

   typedef enum logic {KIND_LOAD, KIND_SAMPLE} kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              load_ok;
      logic [IDX_W-1:0]  entry_index;
      logic [WORD_W-1:0] rate_value;
      logic [WORD_W-1:0] breakpoint_value;
      logic [WORD_W-1:0] uniform_draw;
   } item_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_SAT       = 2'd1,
      ST_ZERO_RATE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      L_IDLE, L_NORM, L_SQ, L_DIFF, L_MUL, L_RND
   } log_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_LOG, B_RDA, B_RDB, B_WID, B_MUL, B_HAZ, B_ACC, B_CHK,
      B_FRD, B_FDAT, B_DIV, B_ADD, B_OUT
   } back_state_type;

endpackage

[design/pes_log.sv]
// serial -ln(1-u) unit: normalize, 26 squaring rounds, scale by ln2 into Q5.26
// depends on pes_pkg
module pes_log
   import pes_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [31:0]      draw,
   output logic             done,
   output logic [W_W-1:0]   w
);

   log_state_type state_ff, state_in;
   logic [31:0] m_ff;
   logic [4:0]  e_ff;
   logic [4:0]  rnd_ff;
   logic [30:0] lg_ff;
   logic [31:0] d_ff;
   logic [63:0] prod_ff;
   logic [63:0] sq;
   logic [32:0] sq_t;
   logic [63:0] rnd_sum;

   assign sq      = 64'(m_ff) * 64'(m_ff);
   assign sq_t    = sq[63:31];
   assign rnd_sum = prod_ff + 64'h8000_0000;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      done     = 1'b0;
      w        = rnd_sum[62:32];
      case (state_ff)
         L_IDLE: begin
            if (start) begin
               state_in = (draw == 32'd0) ? L_RND : L_NORM;
            end
         end
         L_NORM: begin
            if (m_ff[31]) begin
               state_in = L_SQ;
            end
         end
         L_SQ: begin
            if (rnd_ff == 5'd0) begin
               state_in = L_DIFF;
            end
         end
         L_DIFF:  state_in = L_MUL;
         L_MUL:   state_in = L_RND;
         L_RND: begin
            done     = 1'b1;
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         L_IDLE: begin
            m_ff    <= 32'(33'h1_0000_0000 - {1'b0, draw});
            e_ff    <= 5'd31;
            prod_ff <= 64'd0;
         end
         L_NORM: begin
            if (m_ff[31]) begin
               lg_ff  <= {e_ff, 26'd0};
               rnd_ff <= 5'd25;
            end else begin
               m_ff <= {m_ff[30:0], 1'b0};
               e_ff <= e_ff - 5'd1;
            end
         end
         L_SQ: begin
            if (sq_t[32]) begin
               m_ff          <= sq_t[32:1];
               lg_ff[rnd_ff] <= 1'b1;
            end else begin
               m_ff <= sq_t[31:0];
            end
            rnd_ff <= rnd_ff - 5'd1;
         end
         L_DIFF:  d_ff <= 32'h8000_0000 - {1'b0, lg_ff};
         L_MUL:   prod_ff <= 64'(d_ff) * 64'(LN2_Q32);
         default: ;
      endcase
   end

endmodule

[design/pes_div.sv]
// restoring divider, one quotient bit per cycle
// depends on pes_pkg
module pes_div
   import pes_pkg::*;
#(
   parameter int ND = 31,
   parameter int DV = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [ND-1:0] dividend,
   input  logic [DV-1:0] divisor,
   output logic          done,
   output logic [ND-1:0] quotient
);

   localparam int CW = $clog2(ND + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [ND-1:0] dvd_ff;
   logic [ND-1:0] q_ff;
   logic [DV-1:0] dvs_ff;
   logic [DV-1:0] rem_ff;
   logic [DV:0]   rem_sh;
   logic          q_bit;

   assign rem_sh   = {rem_ff, dvd_ff[ND-1]};
   assign q_bit    = rem_sh >= {1'b0, dvs_ff};
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == CW'(1));
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == CW'(1))) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
         cnt_ff <= CW'(ND);
      end else if (busy_ff) begin
         rem_ff <= q_bit ? DV'(rem_sh - {1'b0, dvs_ff}) : DV'(rem_sh);
         q_ff   <= {q_ff[ND-2:0], q_bit};
         dvd_ff <= {dvd_ff[ND-2:0], 1'b0};
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

endmodule

[design/pes_front.sv]
// request intake: unpacks and classifies requests into a two-entry queue
// depends on pes_pkg and the assertion macro header
`include "piecewise_exponential_sampler_assert.svh"
module pes_front
   import pes_pkg::*;
#(
   parameter int MAX_SEGMENTS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic [0:0]   req_tuser,
   output logic         q_valid,
   output item_type     q_item,
   input  logic         q_pop
);

   localparam logic [1:0] DEPTH = 2'd2;

   item_type   slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;
   item_type   item_in;

   assign req_tready = cnt_ff != DEPTH;
   assign push       = req_tvalid && req_tready;
   assign q_valid    = cnt_ff != 2'd0;
   assign pop        = q_pop && q_valid;
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      item_in.kind             = req_tuser[0] ? KIND_SAMPLE : KIND_LOAD;
      item_in.entry_index      = req_tdata[3:0];
      item_in.load_ok          = {28'd0, req_tdata[3:0]} < 32'(MAX_SEGMENTS);
      item_in.rate_value       = req_tdata[35:4];
      item_in.breakpoint_value = req_tdata[67:36];
      item_in.uniform_draw     = req_tdata[99:68];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

   `PES_ASSERT(a_cnt_max, clock, reset, cnt_ff <= DEPTH)
   `PES_ASSERT(a_cnt_up, clock, reset, (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
   `PES_ASSERT_NR(a_cnt_rst, clock, reset |=> (cnt_ff == 2'd0))

endmodule

[design/pes_back.sv]
// execution side: segment tables, hazard walk, division and result register
// depends on pes_pkg, pes_log, pes_div and the assertion macro header
`include "piecewise_exponential_sampler_assert.svh"
module pes_back
   import pes_pkg::*;
#(
   parameter int MAX_SEGMENTS = 16,
   parameter int FRAC_BITS    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] segment_count,
   input  logic             q_valid,
   input  item_type         q_item,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata
);

   localparam int IW    = $clog2(MAX_SEGMENTS);
   localparam int SH_HI = (2 * FRAC_BITS >= W_BITS) ? 2 * FRAC_BITS - W_BITS : 0;
   localparam int SH_LO = (2 * FRAC_BITS < W_BITS) ? W_BITS - 2 * FRAC_BITS : 0;
   localparam int ND    = W_W + SH_HI;
   localparam int DV    = WORD_W + SH_LO;

   back_state_type state_ff, state_in;

   logic [31:0] rate_mem [MAX_SEGMENTS];
   logic [31:0] bp_mem   [MAX_SEGMENTS];
   logic [31:0] rate_rd_ff;
   logic [31:0] bp_rd_ff;
   logic [IW-1:0] raddr;

   logic [IW-1:0]    i_ff;
   logic [IW-1:0]    last_ff;
   logic [IW-1:0]    n_ff;
   logic [W_W-1:0]   w_ff;
   logic [31:0]      a_ff;
   logic [31:0]      r_ff;
   logic [31:0]      wid_ff;
   logic [63:0]      prod_ff;
   logic [HAZ_W-1:0] haz_ff;
   logic [HAZ_W-1:0] cum_ff;
   logic [HAZ_W-1:0] prev_ff;
   logic [HAZ_W-1:0] summ_ff;
   logic [31:0]      bp_n_ff;
   logic [ND-1:0]    q_ff;
   logic [31:0]      res_x_ff;
   status_type       res_st_ff;

   logic             rsp_valid_ff;
   logic [31:0]      out_x_ff;
   logic [IW-1:0]    out_n_ff;
   status_type       out_st_ff;

   logic [31:0]      cnt_c;
   logic [IW-1:0]    last_c;
   logic             log_start;
   logic             log_done;
   logic [W_W-1:0]   log_w;
   logic             div_start;
   logic             div_done;
   logic [ND-1:0]    div_q;
   logic [W_W-1:0]   num;
   logic [63:0]      hz_r;
   logic [HAZ_W-1:0] hz;
   logic [63:0]      cum_sum;
   logic [32:0]      x_sum;
   logic [31:0]      q32;
   logic             q_hi;
   logic             out_free;

   pes_log u_log (
      .clock (clock),
      .reset (reset),
      .start (log_start),
      .draw  (q_item.uniform_draw),
      .done  (log_done),
      .w     (log_w)
   );

   assign num = w_ff - W_W'(summ_ff);

   pes_div #(.ND(ND), .DV(DV)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ND'(num) << SH_HI),
      .divisor  (DV'(rate_rd_ff) << SH_LO),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      cnt_c = {27'd0, segment_count};
      if (cnt_c == 32'd0) begin
         cnt_c = 32'd1;
      end else if (cnt_c > 32'(MAX_SEGMENTS)) begin
         cnt_c = 32'(MAX_SEGMENTS);
      end
      last_c = IW'(cnt_c - 32'd1);
   end

   assign hz_r     = prod_ff >> SH_HI;
   assign hz       = (hz_r > (64'(HAZ_CAP) >> SH_LO)) ? HAZ_CAP : HAZ_W'(hz_r << SH_LO);
   assign cum_sum  = {1'b0, cum_ff} + {1'b0, haz_ff};
   assign q32      = 32'(q_ff);
   assign q_hi     = |(q_ff >> 32);
   assign x_sum    = {1'b0, bp_n_ff} + {1'b0, q32};
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      q_pop     = 1'b0;
      log_start = 1'b0;
      div_start = 1'b0;
      raddr     = i_ff;
      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.kind == KIND_SAMPLE) begin
                  log_start = 1'b1;
                  state_in  = B_LOG;
               end
            end
         end
         B_LOG: begin
            if (log_done) begin
               state_in = (last_ff == '0) ? B_FRD : B_RDA;
            end
         end
         B_RDA: state_in = B_RDB;
         B_RDB: begin
            raddr    = i_ff + IW'(1);
            state_in = B_WID;
         end
         B_WID: state_in = B_MUL;
         B_MUL: state_in = B_HAZ;
         B_HAZ: state_in = B_ACC;
         B_ACC: state_in = B_CHK;
         B_CHK: begin
            if ((63'(w_ff) <= cum_ff) || (i_ff + IW'(1) == last_ff)) begin
               state_in = B_FRD;
            end else begin
               state_in = B_RDA;
            end
         end
         B_FRD: begin
            raddr    = n_ff;
            state_in = B_FDAT;
         end
         B_FDAT: begin
            if (rate_rd_ff == 32'd0) begin
               state_in = B_OUT;
            end else begin
               div_start = 1'b1;
               state_in  = B_DIV;
            end
         end
         B_DIV: begin
            if (div_done) begin
               state_in = B_ADD;
            end
         end
         B_ADD: state_in = B_OUT;
         B_OUT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_IDLE && q_valid && q_item.kind == KIND_LOAD && q_item.load_ok) begin
         rate_mem[IW'(q_item.entry_index)] <= q_item.rate_value;
         bp_mem[IW'(q_item.entry_index)]   <= q_item.breakpoint_value;
      end
      rate_rd_ff <= rate_mem[raddr];
      bp_rd_ff   <= bp_mem[raddr];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: last_ff <= last_c;
         B_LOG: begin
            w_ff    <= log_w;
            i_ff    <= '0;
            n_ff    <= '0;
            cum_ff  <= '0;
            summ_ff <= '0;
         end
         B_RDB: begin
            a_ff <= bp_rd_ff;
            r_ff <= rate_rd_ff;
         end
         B_WID:  wid_ff  <= (bp_rd_ff > a_ff) ? bp_rd_ff - a_ff : 32'd0;
         B_MUL:  prod_ff <= 64'(r_ff) * 64'(wid_ff);
         B_HAZ:  haz_ff  <= hz;
         B_ACC: begin
            prev_ff <= cum_ff;
            cum_ff  <= (cum_sum > 64'(HAZ_CAP)) ? HAZ_CAP : cum_sum[HAZ_W-1:0];
         end
         B_CHK: begin
            if (63'(w_ff) <= cum_ff) begin
               n_ff    <= i_ff;
               summ_ff <= prev_ff;
            end else if (i_ff + IW'(1) == last_ff) begin
               n_ff    <= last_ff;
               summ_ff <= cum_ff;
            end else begin
               i_ff <= i_ff + IW'(1);
            end
         end
         B_FDAT: begin
            bp_n_ff   <= bp_rd_ff;
            res_x_ff  <= 32'hFFFF_FFFF;
            res_st_ff <= ST_ZERO_RATE;
         end
         B_DIV: begin
            if (div_done) begin
               q_ff <= div_q;
            end
         end
         B_ADD: begin
            if (q_hi || x_sum[32]) begin
               res_x_ff  <= 32'hFFFF_FFFF;
               res_st_ff <= ST_SAT;
            end else begin
               res_x_ff  <= x_sum[31:0];
               res_st_ff <= ST_OK;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == B_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_OUT && out_free) begin
         out_x_ff  <= res_x_ff;
         out_n_ff  <= n_ff;
         out_st_ff <= res_st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_st_ff, 4'(out_n_ff), out_x_ff};

   `PES_ASSERT(a_walk_idx, clock, reset, (state_ff == B_CHK) |-> (i_ff < last_ff))
   `PES_ASSERT(a_out_load, clock, reset, (state_ff == B_OUT && out_free) |=> rsp_valid_ff)
   `PES_ASSERT(a_zero_rate, clock, reset, (rsp_valid_ff && out_st_ff == ST_ZERO_RATE) |-> (out_x_ff == 32'hFFFF_FFFF))

endmodule

[design/piecewise_exponential_sampler.sv]
// A load request (tuser 0) writes one rate/breakpoint entry while the
// back end is idle. A sample request (tuser 1) holds the back end while
// it walks k segments, k from 0 up to one less than the segment count in
// use. The work proceeds as follows:
//  - the -ln(1-u) unit normalizes, runs 26 squaring rounds and then the
//    ln2 scaling; a zero draw skips all of these
//  - each segment step passes through the table reads and the
//    rate*width multiplier
//  - the chosen segment is then fetched
//  - the serial divider yields one quotient bit a cycle and then
//    finishes; a zero rate skips the divider
// A two-entry request queue and the result register keep intake and
// delivery running while a sample is computed.
// Top level of the sampler; depends on pes_pkg, pes_front and pes_back.
module piecewise_exponential_sampler
   import pes_pkg::*;
#(
   parameter int MAX_SEGMENTS = 16,
   parameter int FRAC_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // entry_index, rate_value, breakpoint_value, uniform_draw
   input  logic [0:0]   req_tuser,   // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // sample_value, segment_used, status
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data
);

   logic [CNT_W-1:0] seg_count_ff;
   logic             q_valid;
   item_type         q_item;
   logic             q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= 5'd1;
      end else if (csr_valid) begin
         seg_count_ff <= csr_data;
      end
   end

   pes_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   pes_back #(.MAX_SEGMENTS(MAX_SEGMENTS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .segment_count (seg_count_ff),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

[dv/tb.sv]
// testbench for piecewise_exponential_sampler: loads rate/breakpoint tables,
// draws samples and checks each response against an in-bench sampler model
// depends on pes_pkg and the sampler rtl
module tb;
   import pes_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata = '0;   // entry_index, rate_value, breakpoint_value, uniform_draw
   logic [0:0]   req_tuser = '0;   // cmd
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;        // sample_value, segment_used, status
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [4:0]   csr_data = 5'd1;

   piecewise_exponential_sampler DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   typedef struct packed {
      status_type  st;
      logic [3:0]  seg;
      logic [31:0] x;
   } draw_type;

   logic [31:0] rate_mem [16];
   logic [31:0] bp_mem [16];
   logic [4:0]  seg_count = 5'd1;
   draw_type    draw_queue [$];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   int          gap_left = 0;

   function automatic logic [63:0] neg_log(logic [31:0] u);
      logic [63:0] v, m, lg, d, r;
      int e;
      if (u == 0) return 64'd0;
      v = 64'h1_0000_0000 - {32'd0, u};
      e = 31;
      while (e > 0 && v[e] == 1'b0) e--;
      m = v << (31 - e);
      lg = 64'(e) << W_BITS;
      for (int i = W_BITS - 1; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            lg[i] = 1'b1;
         end
      end
      d = (64'd32 << W_BITS) - lg;
      r = (d * 64'(LN2_Q32) + 64'h8000_0000) >> 32;
      return r;
   endfunction

   function automatic draw_type predict_draw(logic [31:0] u);
      logic [63:0] w, cum, summ, num, q, x, cap, wid, haz;
      int cnt, n;
      draw_type d;
      cap = 64'h4000_0000_0000_0000;
      w = neg_log(u);
      cnt = seg_count;
      if (cnt == 0) cnt = 1;
      if (cnt > 16) cnt = 16;
      n = cnt - 1;
      cum = 0;
      summ = 0;
      for (int i = 0; i + 1 < cnt; i++) begin
         wid = bp_mem[i+1] > bp_mem[i] ? 64'(bp_mem[i+1] - bp_mem[i]) : 64'd0;
         summ = cum;
         haz = (64'(rate_mem[i]) * wid) >> 6;
         if (haz > cap) haz = cap;
         cum = cum + haz;
         if (cum > cap) cum = cap;
         if (w <= cum) begin
            n = i;
            break;
         end
         summ = cum;
      end
      num = w - summ;
      d.seg = n[3:0];
      d.st = ST_OK;
      if (rate_mem[n] == 0) begin
         d.x = '1;
         d.st = ST_ZERO_RATE;
      end else begin
         q = (num << 6) / 64'(rate_mem[n]);
         x = 64'(bp_mem[n]) + q;
         if (q > 64'hFFFF_FFFF || x > 64'hFFFF_FFFF) begin
            d.x = '1;
            d.st = ST_SAT;
         end else d.x = x[31:0];
      end
      return d;
   endfunction

   task automatic send_request(kind_type kind, logic [3:0] idx, logic [31:0] rate,
                               logic [31:0] bp, logic [31:0] u);
      if (!calm) begin
         if ($urandom_range(0, 3) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {u, bp, rate, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (kind == KIND_LOAD) begin
         rate_mem[idx] = rate;
         bp_mem[idx] = bp;
      end else draw_queue.push_back(predict_draw(u));
   endtask

   task automatic drain_and_write(logic [4:0] value);
      req_tvalid <= 1'b0;
      while (draw_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      seg_count = value;
   endtask

   task automatic load_table(int count, bit ascending);
      logic [31:0] bp;
      bp = $urandom_range(0, 255) << 8;
      for (int i = 0; i < count; i++) begin
         send_request(KIND_LOAD, i[3:0], $urandom_range(1, 3) << $urandom_range(10, 20),
                      ascending ? bp : $urandom, $urandom);
         bp = bp + ($urandom_range(1, 65535) << $urandom_range(0, 6));
      end
   endtask

   task automatic test_directed();
      for (int i = 0; i < 16; i++)
         send_request(KIND_LOAD, i[3:0], 32'h0001_0000, 32'(i) << 17, '0);
      send_request(KIND_SAMPLE, 4'd0, '0, '0, 32'd0);
      send_request(KIND_SAMPLE, 4'hF, '1, '1, 32'hFFFF_FFFF);
      drain_and_write(5'd16);
      send_request(KIND_SAMPLE, 4'd0, '0, '0, 32'h8000_0000);
      send_request(KIND_SAMPLE, 4'd0, '0, '0, 32'hFFFF_FFFF);
      send_request(KIND_LOAD, 4'd3, 32'd0, 32'h0006_0000, '0);
      send_request(KIND_SAMPLE, 4'd0, '0, '0, 32'hB000_0000);
      send_request(KIND_LOAD, 4'd15, 32'd1, 32'hFFFF_0000, '0);
      send_request(KIND_SAMPLE, 4'd0, '0, '0, 32'hFFFF_FFFF);
      send_request(KIND_LOAD, 4'd2, 32'hFFFF_FFFF, 32'h0000_1000, '0);
      send_request(KIND_SAMPLE, 4'd0, '0, '0, 32'h4000_0000);
      drain_and_write(5'd0);
      send_request(KIND_SAMPLE, 4'd0, '0, '0, 32'h1234_5678);
      drain_and_write(5'd31);
      send_request(KIND_SAMPLE, 4'd0, '0, '0, 32'hF000_0000);
   endtask

   task automatic test_random(int items);
      int sent;
      logic [31:0] u;
      sent = 0;
      while (sent < items) begin
         drain_and_write(5'($urandom_range(0, 20)));
         load_table(16, $urandom_range(0, 4) != 0);
         sent += 16;
         if ($urandom_range(0, 2) == 0) begin
            send_request(KIND_LOAD, 4'($urandom), $urandom, $urandom, $urandom);
            sent++;
         end
         repeat (30) begin
            case ($urandom_range(0, 3))
               0: u = $urandom;
               1: u = $urandom_range(0, 65535);
               2: u = ~32'($urandom_range(0, 65535));
               default: u = $urandom >> $urandom_range(0, 31);
            endcase
            send_request(KIND_SAMPLE, 4'($urandom), $urandom, $urandom, u);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (calm || gap_left == 0) begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) gap_left <= $urandom_range(1, 3);
         end else begin
            rsp_tready <= 1'b0;
            gap_left <= gap_left - 1;
         end
      end
   end

   always @(posedge clock) begin
      draw_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[37:0];
         if (draw_queue.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = draw_queue.pop_front();
            if (got.x !== want.x || got.seg !== want.seg || got.st !== want.st ||
                rsp_tdata[39:38] !== 2'b00) begin
               $display("%0t: mismatch expected x=%h seg=%0d st=%0d actual x=%h seg=%0d st=%0d",
                        $time, want.x, want.seg, want.st, got.x, got.seg, got.st);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1300);
      calm = 1'b1;
      test_random(200);
      req_tvalid <= 1'b0;
      while (draw_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end
endmodule
